// File: hw/rtl/odrgb_pkg.sv
// ----------------------------------------------------------------------------
// odrgb_pkg
// Shared widths, register indexes and the 4x4 offset table for the
// RGB555 ordered dither block.
// ----------------------------------------------------------------------------
package odrgb_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;                 // width of a dimension register
    localparam int CNT_W     = $clog2(MAX_DIM);    // column / row counter width
    localparam int CHAN_W    = 8;
    localparam int OFF_W     = 4;                  // signed offset -4..+3
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CHAN_W-1:0] QUANT_MASK = 8'b1111_1000;
    localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

    // low bits of the current pixel position, used to index the table
    typedef struct packed {
        logic [1:0] col;
        logic [1:0] row;
    } t_pos;

    // table index = {row[1:0], col[1:0]}
    function automatic logic signed [OFF_W-1:0] grid_offset(input t_pos pos);
        logic signed [OFF_W-1:0] off;
        case ({pos.row, pos.col})
            4'd0:    off = -4'sd4;
            4'd1:    off =  4'sd0;
            4'd2:    off = -4'sd3;
            4'd3:    off =  4'sd1;
            4'd4:    off =  4'sd2;
            4'd5:    off = -4'sd2;
            4'd6:    off =  4'sd3;
            4'd7:    off = -4'sd1;
            4'd8:    off = -4'sd3;
            4'd9:    off =  4'sd1;
            4'd10:   off = -4'sd4;
            4'd11:   off =  4'sd0;
            4'd12:   off =  4'sd3;
            4'd13:   off = -4'sd1;
            4'd14:   off =  4'sd2;
            4'd15:   off = -4'sd2;
            default: off =  4'sd0;
        endcase
        return off;
    endfunction

endpackage

// File: hw/rtl/ordered_dither_rgb555_top.sv
// ----------------------------------------------------------------------------
// ordered_dither_rgb555_top
// 4x4 ordered dither of a raster RGB888 pixel stream down to RGB555
// (each channel returned as 8 bits with the low three bits cleared).
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  in       | i_in_valid / o_in_ready   | i_red_in, i_green_in, i_blue_in,
//           |                           | i_frame_start
//  out      | o_out_valid / i_out_ready | o_red_out, o_green_out, o_blue_out
//  cfg      | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
//  One pixel per clock unless the sink stalls: an accepted item shows at the output in the next cycle.
//  The position counters and offset lookup plus the three saturating adders
//  sit in front of a single result register, which is the only stage.
//  o_in_ready drops only while a result is held and the sink stalls.
//  Synchronous active-low reset: width 640, height 480, counters at zero,
//  output empty.
// ----------------------------------------------------------------------------
module ordered_dither_rgb555_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [odrgb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [odrgb_pkg::DIM_W-1:0]     i_cfg_data,
    // pixel in
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [odrgb_pkg::CHAN_W-1:0]    i_red_in,
    input  logic [odrgb_pkg::CHAN_W-1:0]    i_green_in,
    input  logic [odrgb_pkg::CHAN_W-1:0]    i_blue_in,
    input  logic                            i_frame_start,
    // pixel out
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [odrgb_pkg::CHAN_W-1:0]    o_red_out,
    output logic [odrgb_pkg::CHAN_W-1:0]    o_green_out,
    output logic [odrgb_pkg::CHAN_W-1:0]    o_blue_out
);
    import odrgb_pkg::*;

    logic                     in_acc;
    t_pos                     pos;
    logic signed [OFF_W-1:0]  off;
    logic [CHAN_W-1:0]        red_d, green_d, blue_d;

    logic                     r_valid;
    logic [CHAN_W-1:0]        r_red, r_green, r_blue;

    // result register frees up in the same cycle it is taken
    assign o_in_ready = !r_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    odrgb_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_adv         (in_acc),
        .i_frame_start (i_frame_start),
        .o_pos         (pos)
    );

    // same offset for all three channels
    assign off = grid_offset(pos);

    odrgb_chan u_red   (.i_chan(i_red_in),   .i_off(off), .o_chan(red_d));
    odrgb_chan u_green (.i_chan(i_green_in), .i_off(off), .o_chan(green_d));
    odrgb_chan u_blue  (.i_chan(i_blue_in),  .i_off(off), .o_chan(blue_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_red   <= red_d;
            r_green <= green_d;
            r_blue  <= blue_d;
        end
    end

    assign o_out_valid = r_valid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

`ifndef SYNTHESIS
    // accepted item always lands in the result register
    a_acc_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted item did not reach output");

    // held result with stalled sink blocks the input
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output stalled");

    // quantization leaves low bits clear on every channel
    a_quant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_red_out[2:0] | o_green_out[2:0] | o_blue_out[2:0]) == 3'b000))
        else $error("low channel bits not cleared");
`endif

endmodule

// File: hw/rtl/odrgb_pos.sv
// ----------------------------------------------------------------------------
// odrgb_pos
// Image dimension registers and raster column / row counters.
// ----------------------------------------------------------------------------
module odrgb_pos (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [odrgb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [odrgb_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                            i_adv,
    input  logic                            i_frame_start,
    output odrgb_pkg::t_pos                 o_pos
);
    import odrgb_pkg::*;

    logic [DIM_W-1:0] r_width, r_height;
    logic [CNT_W-1:0] r_col, r_row;
    logic [CNT_W-1:0] n_col, n_row;
    logic [CNT_W-1:0] cur_col, cur_row;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [DIM_W-1:0] col_inc, row_inc;

    // zero acts as one, anything above MAX_DIM acts as MAX_DIM
    always_comb begin
        if (r_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_DIM)) begin
            w_eff = DIM_W'(MAX_DIM);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_DIM)) begin
            h_eff = DIM_W'(MAX_DIM);
        end else begin
            h_eff = r_height;
        end
    end

    // frame start treats this pixel as column 0 of row 0
    assign cur_col = i_frame_start ? '0 : r_col;
    assign cur_row = i_frame_start ? '0 : r_row;
    assign col_inc = {1'b0, cur_col} + DIM_W'(1);
    assign row_inc = {1'b0, cur_row} + DIM_W'(1);

    always_comb begin
        n_col = col_inc[CNT_W-1:0];
        n_row = cur_row;
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_inc >= h_eff) ? '0 : row_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(480);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_idx == REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            if (i_adv) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    assign o_pos.col = cur_col[1:0];
    assign o_pos.row = cur_row[1:0];

endmodule

// File: hw/rtl/odrgb_chan.sv
// ----------------------------------------------------------------------------
// odrgb_chan
// One color channel: add signed offset, saturate to 0..255, keep top 5 bits.
// ----------------------------------------------------------------------------
module odrgb_chan (
    input  logic [odrgb_pkg::CHAN_W-1:0]        i_chan,
    input  logic signed [odrgb_pkg::OFF_W-1:0]  i_off,
    output logic [odrgb_pkg::CHAN_W-1:0]        o_chan
);
    import odrgb_pkg::*;

    logic signed [CHAN_W+1:0] sum;
    logic [CHAN_W-1:0]        sat;

    assign sum = $signed({2'b00, i_chan}) + (CHAN_W+2)'(i_off);

    always_comb begin
        if (sum < 0) begin
            sat = '0;
        end else if (sum > $signed({2'b00, CHAN_MAX})) begin
            sat = CHAN_MAX;
        end else begin
            sat = sum[CHAN_W-1:0];
        end
    end

    assign o_chan = sat & QUANT_MASK;

endmodule
